/* hdl/sra_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// sra_pkg
// Shared types and constants of the signed radix-to-text converter: field
// widths, register indexes, reset values and the controller states.
// ============================================================================
package sra_pkg;

    localparam int VALUE_W   = 32;
    localparam int RADIX_W   = 5;
    localparam int DIGITS_W  = 64;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam int MAX_RADIX_DEF  = 16;
    localparam int VALUE_BITS_DEF = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]  RADIX_RST       = 5'd10;
    localparam logic [DIGITS_W-1:0] DIGITS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [DIGITS_W-1:0] DIGITS_HIGH_RST = 64'h0000_0000_0000_3938;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIGN,
        ST_EMIT
    } state_t;

endpackage

/* hdl/signed_radix_to_ascii.sv */
`timescale 1ns / 1ps
// ============================================================================
// signed_radix_to_ascii
// Converts a signed integer into its text in a configurable base, one
// character per output transfer, with a minus sign first for negative values.
// ============================================================================
// Usage: each input transfer on s_value carries one two's complement value.
// The block answers with a sign character when the value is negative and
// then the digit characters, most significant first; m_last_char marks the
// final character. If the base set by the configuration is invalid, the value
// produces no output at all. Registers are written through the cfg channel,
// which is always ready and should only be used while the block is idle.
// The magnitude enters a row of digit cells one bit per cycle, MSB first,
// while the base is checked in parallel, one digit character per cycle.
// The output phase then steps through the digit cells, most significant
// first, after a minus sign for a negative value. One item is in work at a
// time; s_ready is high only between items. The output register lets the
// next item start while the last character still waits. A stall on m_ready
// holds the character and pauses the digit shift, though leading zeros are
// still skipped. Reset restores the default decimal configuration and
// empties the output register.
// ============================================================================
module signed_radix_to_ascii #(
    parameter int MAX_RADIX  = sra_pkg::MAX_RADIX_DEF,
    parameter int VALUE_BITS = sra_pkg::VALUE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sra_pkg::VALUE_W-1:0]  s_value,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [sra_pkg::CHAR_W-1:0]   m_char_out,
    output logic                                m_last_char,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic        [sra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [sra_pkg::DIGITS_W-1:0] cfg_data
);

    localparam int NDIG = VALUE_BITS + 1;
    localparam int DW   = $clog2(MAX_RADIX);
    localparam int CW   = $clog2(MAX_RADIX + 1);
    localparam int BCW  = $clog2(NDIG + 1);
    localparam int LVL  = $clog2(NDIG);
    localparam int RW   = sra_pkg::RADIX_W;
    localparam int CHW  = sra_pkg::CHAR_W;

    sra_pkg::state_t state_reg, state_next;

    logic [RW-1:0]                radix_reg;
    logic [sra_pkg::DIGITS_W-1:0] digits_low_reg, digits_high_reg;

    logic [VALUE_BITS:0] mag_reg, mag_next;
    logic [BCW-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [BCW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]       chk_idx_reg, chk_idx_next;
    logic                bad_reg, bad_next;
    logic                neg_reg, neg_next;
    logic                lead_reg, lead_next;
    logic [DW-1:0]       dig_reg  [0:NDIG-1];
    logic [DW-1:0]       dig_next [0:NDIG-1];
    logic [DW-1:0]       conv_dig [0:NDIG-1];

    logic            m_valid_reg, m_valid_next;
    logic [CHW-1:0]  m_char_reg, m_char_next;
    logic            m_last_reg, m_last_next;

    logic [CHW-1:0]  chars [0:MAX_RADIX-1];

    logic [VALUE_BITS-1:0] v_in;
    logic                  neg_in;
    logic [VALUE_BITS:0]   mag_in;
    logic                  in_xfer;
    logic                  out_free;
    logic                  conv_done;
    logic                  chk_done;
    logic                  chk_bad;
    logic [CHW-1:0]        chk_char;
    logic [RW-1:0]         chk_ext;
    logic [DW-1:0]         top_dig;
    logic                  skip_zero;

    logic [DW:0]      r_t;
    logic [DW:0]      sum_t;
    logic [NDIG-1:0]  gen_v, prp_v, cout_v;
    logic [NDIG-1:0]  gv [0:LVL];
    logic [NDIG-1:0]  pv [0:LVL];

    // Digit character table taken from the two configuration registers.
    for (genvar k = 0; k < MAX_RADIX; k++) begin : g_char
        if (k < 8) begin : g_low
            assign chars[k] = digits_low_reg[CHW*k +: CHW];
        end else begin : g_high
            assign chars[k] = digits_high_reg[CHW*(k-8) +: CHW];
        end
    end

    assign v_in   = s_value[VALUE_BITS-1:0];
    assign neg_in = v_in[VALUE_BITS-1];
    assign mag_in = neg_in ? ({1'b1, {VALUE_BITS{1'b0}}} - {1'b0, v_in}) : {1'b0, v_in};

    assign s_ready   = (state_reg == sra_pkg::ST_IDLE);
    assign in_xfer   = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    assign m_valid     = m_valid_reg;
    assign m_char_out  = m_char_reg;
    assign m_last_char = m_last_reg;

    assign conv_done = (bit_cnt_reg == '0);
    assign chk_done  = (chk_idx_reg == CW'(MAX_RADIX));
    assign chk_ext   = RW'(chk_idx_reg);
    assign chk_char  = chars[chk_idx_reg[DW-1:0]];
    assign top_dig   = dig_reg[NDIG-1];
    assign skip_zero = lead_reg && (top_dig == '0) && (cnt_reg != BCW'(1));
    assign r_t       = radix_reg[DW:0];

    // One check step: the character at chk_idx against the forbidden codes
    // and against every higher digit character in use.
    always_comb begin
        chk_bad = 1'b0;
        if (chk_ext < radix_reg) begin
            if (chk_char == sra_pkg::CHAR_NUL || chk_char == sra_pkg::CHAR_MINUS ||
                chk_char == sra_pkg::CHAR_PLUS) begin
                chk_bad = 1'b1;
            end
            for (int j = 0; j < MAX_RADIX; j++) begin
                if (RW'(j) > chk_ext && RW'(j) < radix_reg && chars[j] == chk_char) begin
                    chk_bad = 1'b1;
                end
            end
        end
    end

    // Doubling of the digit row plus the incoming bit, with the carries
    // resolved by a parallel prefix network.
    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            gen_v[k] = ({dig_reg[k], 1'b0} >= r_t);
            prp_v[k] = ({dig_reg[k], 1'b1} == r_t);
        end
        gv[0]    = gen_v;
        pv[0]    = prp_v;
        gv[0][0] = gen_v[0] | (prp_v[0] & mag_reg[VALUE_BITS]);
        pv[0][0] = 1'b0;
        for (int s = 0; s < LVL; s++) begin
            for (int k = 0; k < NDIG; k++) begin
                if (k >= (1 << s)) begin
                    gv[s+1][k] = gv[s][k] | (pv[s][k] & gv[s][k - (1 << s)]);
                    pv[s+1][k] = pv[s][k] & pv[s][k - (1 << s)];
                end else begin
                    gv[s+1][k] = gv[s][k];
                    pv[s+1][k] = pv[s][k];
                end
            end
        end
        cout_v = gv[LVL];
        for (int k = 0; k < NDIG; k++) begin
            sum_t       = {dig_reg[k], (k == 0) ? mag_reg[VALUE_BITS] : cout_v[(k == 0) ? 0 : k-1]};
            conv_dig[k] = DW'(sum_t - (cout_v[k] ? r_t : '0));
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sra_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    state_next = sra_pkg::ST_CONV;
                end
            end
            sra_pkg::ST_CONV: begin
                if (conv_done && chk_done) begin
                    if (bad_reg) begin
                        state_next = sra_pkg::ST_IDLE;
                    end else if (neg_reg) begin
                        state_next = sra_pkg::ST_SIGN;
                    end else begin
                        state_next = sra_pkg::ST_EMIT;
                    end
                end
            end
            sra_pkg::ST_SIGN: begin
                if (out_free) begin
                    state_next = sra_pkg::ST_EMIT;
                end
            end
            sra_pkg::ST_EMIT: begin
                if (!skip_zero && out_free && cnt_reg == BCW'(1)) begin
                    state_next = sra_pkg::ST_IDLE;
                end
            end
            default: state_next = sra_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        mag_next     = mag_reg;
        bit_cnt_next = bit_cnt_reg;
        cnt_next     = cnt_reg;
        chk_idx_next = chk_idx_reg;
        bad_next     = bad_reg;
        neg_next     = neg_reg;
        lead_next    = lead_reg;
        dig_next     = dig_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        unique case (state_reg)
            sra_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    mag_next     = mag_in;
                    neg_next     = neg_in;
                    bit_cnt_next = BCW'(NDIG);
                    chk_idx_next = '0;
                    bad_next     = (radix_reg < RW'(2)) || (radix_reg > RW'(MAX_RADIX));
                    for (int k = 0; k < NDIG; k++) begin
                        dig_next[k] = '0;
                    end
                end
            end
            sra_pkg::ST_CONV: begin
                if (!conv_done) begin
                    mag_next     = {mag_reg[VALUE_BITS-1:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - BCW'(1);
                    dig_next     = conv_dig;
                end
                if (!chk_done) begin
                    chk_idx_next = chk_idx_reg + CW'(1);
                    bad_next     = bad_reg | chk_bad;
                end
                cnt_next  = BCW'(NDIG);
                lead_next = 1'b1;
            end
            sra_pkg::ST_SIGN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = sra_pkg::CHAR_MINUS;
                    m_last_next  = 1'b0;
                end
            end
            sra_pkg::ST_EMIT: begin
                if (skip_zero || out_free) begin
                    for (int k = NDIG - 1; k > 0; k--) begin
                        dig_next[k] = dig_reg[k-1];
                    end
                    dig_next[0] = '0;
                    cnt_next    = cnt_reg - BCW'(1);
                end
                if (!skip_zero && out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = chars[top_dig];
                    m_last_next  = (cnt_reg == BCW'(1));
                    lead_next    = 1'b0;
                end
            end
            default: begin
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= sra_pkg::ST_IDLE;
            m_valid_reg     <= 1'b0;
            radix_reg       <= sra_pkg::RADIX_RST;
            digits_low_reg  <= sra_pkg::DIGITS_LOW_RST;
            digits_high_reg <= sra_pkg::DIGITS_HIGH_RST;
            bit_cnt_reg     <= '0;
            chk_idx_reg     <= '0;
            cnt_reg         <= '0;
            lead_reg        <= 1'b0;
            bad_reg         <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            bit_cnt_reg <= bit_cnt_next;
            chk_idx_reg <= chk_idx_next;
            cnt_reg     <= cnt_next;
            lead_reg    <= lead_next;
            bad_reg     <= bad_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sra_pkg::CFG_RADIX:       radix_reg       <= cfg_data[RW-1:0];
                    sra_pkg::CFG_DIGITS_LOW:  digits_low_reg  <= cfg_data;
                    sra_pkg::CFG_DIGITS_HIGH: digits_high_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        dig_reg     <= dig_next;
        m_char_reg  <= m_char_next;
        m_last_reg  <= m_last_next;
    end

    // After every magnitude bit has entered the digit row, the shifter is empty.
    a_mag_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sra_pkg::ST_CONV && bit_cnt_reg == '0) |-> (mag_reg == '0))
        else $error("magnitude not fully shifted at end of conversion");

    // An accepted value always starts a conversion.
    a_start_conv: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == sra_pkg::ST_CONV))
        else $error("input transfer did not start a conversion");

    // The output phase never runs with its digit count used up.
    a_emit_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sra_pkg::ST_EMIT) |-> (cnt_reg != '0))
        else $error("digit count exhausted during output");

    // The sign phase is only entered for negative values.
    a_sign_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == sra_pkg::ST_SIGN) |-> neg_reg)
        else $error("minus sign for a non-negative value");

endmodule

/* tb/tb_signed_radix_to_ascii.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_signed_radix_to_ascii
// Self-checking testbench for the signed radix-to-text converter. A directed
// part covers the value extremes, both ends of the radix range, rejected
// digit sets and an ignored register index. A random part then converts
// random values under random digit sets. Every character transfer is checked
// against a local prediction while the sender idles in bursts and the
// receiver stalls.
// ============================================================================
module tb_signed_radix_to_ascii;

    localparam int CLK_HALF_NS    = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int BUSY_GUARD     = 150;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT    = 50000;
    localparam int N_ROUNDS       = 10;
    localparam int ROUND_VALUES   = 27;

    localparam logic [sra_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [sra_pkg::DIGITS_W-1:0]  HEX_LOW    = 64'h3736_3534_3332_3130;
    localparam logic [sra_pkg::DIGITS_W-1:0]  HEX_HIGH   = 64'h4645_4443_4241_3938;
    localparam logic [sra_pkg::DIGITS_W-1:0]  BIN_LOW    = 64'h0000_0000_0000_3130;

    typedef struct packed {
        logic [sra_pkg::CHAR_W-1:0] ch;
        logic                       last;
    } text_char_t;

    typedef enum int {
        RX_ALWAYS,
        RX_PATTERN,
        RX_SPARSE
    } rx_mode_t;

    logic                                aclk        = 1'b0;
    logic                                aresetn     = 1'b0;
    logic                                s_valid     = 1'b0;
    logic                                s_ready;
    logic signed [sra_pkg::VALUE_W-1:0]  s_value     = '0;
    logic                                m_valid;
    logic                                m_ready     = 1'b0;
    logic [sra_pkg::CHAR_W-1:0]          m_char_out;
    logic                                m_last_char;
    logic                                cfg_valid   = 1'b0;
    logic                                cfg_ready;
    logic [sra_pkg::CFG_IDX_W-1:0]       cfg_index   = '0;
    logic [sra_pkg::DIGITS_W-1:0]        cfg_data    = '0;

    logic [sra_pkg::RADIX_W-1:0]  cfg_radix       = sra_pkg::RADIX_RST;
    logic [sra_pkg::DIGITS_W-1:0] cfg_digits_low  = sra_pkg::DIGITS_LOW_RST;
    logic [sra_pkg::DIGITS_W-1:0] cfg_digits_high = sra_pkg::DIGITS_HIGH_RST;

    text_char_t  pending_chars[$];
    int unsigned fail_count        = 0;
    int unsigned chars_checked     = 0;
    int unsigned values_sent       = 0;
    int unsigned base_settings     = 0;
    int unsigned rejected_settings = 0;
    int unsigned burst_left        = 0;
    bit          tx_steady         = 1'b0;
    bit          rx_hold_req       = 1'b0;
    rx_mode_t    rx_mode           = RX_PATTERN;

    signed_radix_to_ascii dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_char_out  (m_char_out),
        .m_last_char (m_last_char),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always begin
        #CLK_HALF_NS aclk = 1'b1;
        #CLK_HALF_NS aclk = 1'b0;
    end

    function automatic logic [sra_pkg::CHAR_W-1:0] digit_for(int unsigned d);
        if (d < 8) begin
            return cfg_digits_low[8*d +: 8];
        end
        return cfg_digits_high[8*(d-8) +: 8];
    endfunction

    function automatic bit base_valid();
        int unsigned n;
        logic [sra_pkg::CHAR_W-1:0] c;
        n = cfg_radix;
        if (n < 2 || n > sra_pkg::MAX_RADIX_DEF) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            c = digit_for(i);
            if (c == sra_pkg::CHAR_NUL || c == sra_pkg::CHAR_MINUS ||
                c == sra_pkg::CHAR_PLUS) begin
                return 1'b0;
            end
            for (int j = i + 1; j < n; j++) begin
                if (c == digit_for(j)) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(logic signed [sra_pkg::VALUE_W-1:0] v);
        logic [sra_pkg::VALUE_W:0]  mag;
        logic [sra_pkg::CHAR_W-1:0] digs[$];
        int unsigned                r;
        if (!base_valid()) begin
            return;
        end
        r   = cfg_radix;
        mag = v[sra_pkg::VALUE_W-1] ?
              ({1'b1, {sra_pkg::VALUE_W{1'b0}}} - {1'b0, v}) : {1'b0, v};
        do begin
            digs.push_back(digit_for(mag % r));
            mag = mag / r;
        end while (mag != 0);
        if (v[sra_pkg::VALUE_W-1]) begin
            pending_chars.push_back('{ch: sra_pkg::CHAR_MINUS, last: 1'b0});
        end
        for (int i = digs.size() - 1; i >= 0; i--) begin
            pending_chars.push_back('{ch: digs[i], last: (i == 0)});
        end
    endfunction

    function automatic logic signed [sra_pkg::VALUE_W-1:0] random_value();
        logic signed [sra_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 600) - 300;
            1: v = $urandom >> $urandom_range(0, 31);
            2: v = -($urandom >> $urandom_range(0, 31));
            3: begin
                case ($urandom_range(0, 3))
                    0: v = {1'b1, {(sra_pkg::VALUE_W-1){1'b0}}};
                    1: v = {1'b0, {(sra_pkg::VALUE_W-1){1'b1}}};
                    2: v = '1;
                    default: v = '0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic signed [sra_pkg::VALUE_W-1:0] v);
        int unsigned gap;
        @(posedge aclk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = tx_steady ? 0 : $urandom_range(0, 80);
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_value <= v;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_text(v);
        values_sent++;
        s_valid <= 1'b0;
    endtask

    task automatic cfg_write(input logic [sra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sra_pkg::DIGITS_W-1:0] data);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            sra_pkg::CFG_RADIX:       cfg_radix       = data[sra_pkg::RADIX_W-1:0];
            sra_pkg::CFG_DIGITS_LOW:  cfg_digits_low  = data;
            sra_pkg::CFG_DIGITS_HIGH: cfg_digits_high = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    // A value converted under a rejected base produces no transfer, so the
    // block may still be busy after the last expected character.
    task automatic wait_idle();
        wait_for_drain();
        repeat (BUSY_GUARD) @(posedge aclk);
    endtask

    task automatic apply_base(input logic [sra_pkg::RADIX_W-1:0] r,
                              input logic [sra_pkg::DIGITS_W-1:0] lo,
                              input logic [sra_pkg::DIGITS_W-1:0] hi);
        logic [sra_pkg::DIGITS_W-1:0] radix_word;
        wait_idle();
        radix_word = {$urandom, $urandom};
        radix_word[sra_pkg::RADIX_W-1:0] = r;
        cfg_write(sra_pkg::CFG_RADIX, radix_word);
        cfg_write(sra_pkg::CFG_DIGITS_LOW, lo);
        cfg_write(sra_pkg::CFG_DIGITS_HIGH, hi);
        base_settings++;
        if (!base_valid()) begin
            rejected_settings++;
        end
    endtask

    task automatic random_base(input int unsigned fixed_radix, input bit want_valid);
        logic [sra_pkg::CHAR_W-1:0]   b[16];
        logic [255:0]                 taken;
        logic [sra_pkg::DIGITS_W-1:0] lo;
        logic [sra_pkg::DIGITS_W-1:0] hi;
        int unsigned                  r;
        int unsigned                  i;
        int unsigned                  j;
        taken = '0;
        r = (fixed_radix != 0) ? fixed_radix : $urandom_range(2, sra_pkg::MAX_RADIX_DEF);
        for (i = 0; i < 16; i++) begin
            if (i < r) begin
                do b[i] = $urandom_range(1, 255);
                while (taken[b[i]] || b[i] == sra_pkg::CHAR_MINUS ||
                       b[i] == sra_pkg::CHAR_PLUS);
                taken[b[i]] = 1'b1;
            end else begin
                b[i] = $urandom_range(0, 255);
            end
        end
        if (!want_valid) begin
            i = $urandom_range(0, r - 1);
            case ($urandom_range(0, 3))
                0: r = $urandom_range(0, 1);
                1: r = $urandom_range(sra_pkg::MAX_RADIX_DEF + 1, 31);
                2: begin
                    case ($urandom_range(0, 2))
                        0: b[i] = sra_pkg::CHAR_NUL;
                        1: b[i] = sra_pkg::CHAR_MINUS;
                        default: b[i] = sra_pkg::CHAR_PLUS;
                    endcase
                end
                default: begin
                    j = (i + $urandom_range(1, r - 1)) % r;
                    b[j] = b[i];
                end
            endcase
        end
        for (i = 0; i < 8; i++) begin
            lo[8*i +: 8] = b[i];
            hi[8*i +: 8] = b[i+8];
        end
        apply_base(r[sra_pkg::RADIX_W-1:0], lo, hi);
    endtask

    task automatic test_decimal_extremes();
        send_value(0);
        send_value(1);
        send_value(-1);
        send_value(9);
        send_value(-10);
        send_value(12345);
        send_value({1'b0, {(sra_pkg::VALUE_W-1){1'b1}}});
        send_value({1'b1, {(sra_pkg::VALUE_W-1){1'b0}}});
        send_value({1'b1, {(sra_pkg::VALUE_W-2){1'b0}}, 1'b1});
    endtask

    task automatic test_cfg_index_out_of_range();
        wait_idle();
        cfg_write(CFG_UNUSED, {$urandom, $urandom});
        send_value(-2468);
    endtask

    task automatic test_radix_extremes();
        apply_base(5'd2, BIN_LOW, '0);
        send_value({1'b1, {(sra_pkg::VALUE_W-1){1'b0}}});
        send_value({1'b0, {(sra_pkg::VALUE_W-1){1'b1}}});
        apply_base(5'd16, HEX_LOW, HEX_HIGH);
        send_value(-1);
        send_value(32'hDEAD_BEEF);
    endtask

    task automatic test_unused_digits();
        apply_base(5'd8, sra_pkg::DIGITS_LOW_RST, {8{sra_pkg::CHAR_MINUS}});
        send_value(-8);
        send_value(511);
    endtask

    task automatic test_invalid_bases();
        logic [sra_pkg::DIGITS_W-1:0] lo;
        logic [sra_pkg::DIGITS_W-1:0] hi;
        apply_base(5'd0, sra_pkg::DIGITS_LOW_RST, sra_pkg::DIGITS_HIGH_RST);
        send_value(-5);
        apply_base(5'd1, sra_pkg::DIGITS_LOW_RST, sra_pkg::DIGITS_HIGH_RST);
        send_value(7);
        apply_base(5'd17, HEX_LOW, HEX_HIGH);
        send_value(100);
        apply_base(5'd31, HEX_LOW, HEX_HIGH);
        send_value(-100);
        lo = sra_pkg::DIGITS_LOW_RST;
        lo[8*3 +: 8] = sra_pkg::CHAR_MINUS;
        apply_base(sra_pkg::RADIX_RST, lo, sra_pkg::DIGITS_HIGH_RST);
        send_value(123);
        hi = sra_pkg::DIGITS_HIGH_RST;
        hi[15:8] = sra_pkg::CHAR_PLUS;
        apply_base(sra_pkg::RADIX_RST, sra_pkg::DIGITS_LOW_RST, hi);
        send_value(-99);
        lo = sra_pkg::DIGITS_LOW_RST;
        lo[7:0] = sra_pkg::CHAR_NUL;
        apply_base(sra_pkg::RADIX_RST, lo, sra_pkg::DIGITS_HIGH_RST);
        send_value(0);
        hi = HEX_HIGH;
        hi[8*7 +: 8] = HEX_LOW[7:0];
        apply_base(5'd16, HEX_LOW, hi);
        send_value(-1);
    endtask

    task automatic test_output_backpressure();
        apply_base(5'd2, BIN_LOW, {$urandom, $urandom});
        rx_hold_req = 1'b1;
        tx_steady   = 1'b1;
        repeat (6) send_value($urandom | 32'h8000_0000);
        tx_steady   = 1'b0;
    endtask

    task automatic test_drain_pause();
        apply_base(5'd16, HEX_LOW, HEX_HIGH);
        rx_mode = RX_PATTERN;
        repeat (5) send_value(random_value());
        wait_for_drain();
        repeat (5) send_value(random_value());
    endtask

    task automatic test_random_bases();
        int unsigned fixed_radix;
        bit          want_valid;
        for (int round = 0; round < N_ROUNDS; round++) begin
            rx_mode     = rx_mode_t'(round % 3);
            tx_steady   = (round % 4 == 3);
            fixed_radix = (round == 0) ? 2 : (round == 1) ? sra_pkg::MAX_RADIX_DEF : 0;
            want_valid  = (round % 5 != 4);
            random_base(fixed_radix, want_valid);
            repeat (want_valid ? ROUND_VALUES : 4) send_value(random_value());
        end
        tx_steady = 1'b0;
    endtask

    // Receiver: always ready, a rotating random ready pattern, a sparse mode,
    // and a long hold-off on request.
    initial begin
        logic [15:0] rx_pattern;
        int unsigned rx_phase;
        rx_pattern = $urandom;
        rx_phase   = 0;
        forever begin
            @(posedge aclk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
            end else begin
                case (rx_mode)
                    RX_ALWAYS: m_ready <= 1'b1;
                    RX_SPARSE: m_ready <= ($urandom_range(0, 7) == 0);
                    default:   m_ready <= rx_pattern[rx_phase];
                endcase
                rx_phase = (rx_phase + 1) % 16;
                if (rx_phase == 0) begin
                    rx_pattern = $urandom;
                end
            end
        end
    end

    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, actual char %h last %b",
                         $time, m_char_out, m_last_char);
                fail_count++;
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_char_out !== want.ch) begin
                    $display("%0t: char_out mismatch, expected %h actual %h",
                             $time, want.ch, m_char_out);
                    fail_count++;
                end
                if (m_last_char !== want.last) begin
                    $display("%0t: last_char mismatch, expected %b actual %b",
                             $time, want.last, m_last_char);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        int unsigned drain_cycles;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_decimal_extremes();
        test_cfg_index_out_of_range();
        test_radix_extremes();
        test_unused_digits();
        test_invalid_bases();
        test_output_backpressure();
        test_drain_pause();
        test_random_bases();
        rx_mode = RX_ALWAYS;
        drain_cycles = 0;
        while (pending_chars.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_cycles++;
        end
        if (pending_chars.size() != 0) begin
            $display("%0t: %0d expected characters never arrived", $time, pending_chars.size());
            fail_count++;
        end
        repeat (BUSY_GUARD) @(posedge aclk);
        $display("Sent %0d values under %0d base settings, %0d of them rejected.",
                 values_sent, base_settings, rejected_settings);
        $display("Checked %0d characters with sender gaps, receiver stalls and a long hold-off.",
                 chars_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout", $time);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* files.f */
hdl/sra_pkg.sv
hdl/signed_radix_to_ascii.sv
tb/tb_signed_radix_to_ascii.sv
